// File: src/max_frequency_stack_macros.svh
// Assertion macros used by the RTL file max_frequency_stack.sv.
`ifndef MAX_FREQUENCY_STACK_MACROS_SVH
`define MAX_FREQUENCY_STACK_MACROS_SVH

// Property that must hold at every edge outside reset.
`define MFS_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication outside reset.
`define MFS_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication outside reset.
`define MFS_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/mfs_pkg.sv
package mfs_pkg;

  // Value and store sizing
  localparam int VALUE_BITS = 8;
  localparam int NUM_VALUES = 1 << VALUE_BITS;
  localparam int CAPACITY   = 64;
  localparam int SLOT_W     = $clog2(CAPACITY);
  localparam int LVL_W      = $clog2(CAPACITY + 1);

  // Null link: one past the last slot
  localparam logic [LVL_W-1:0] NONE_SLOT = LVL_W'(CAPACITY);

  // Operation codes
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic       cmd;
    logic [7:0] push_value;
  } mfs_in_t;

  typedef struct packed {
    logic [7:0] pop_value;
    logic [1:0] status;
    logic [6:0] top_level;
  } mfs_out_t;

  // One entry of the shared list store
  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [LVL_W-1:0]      below;
  } mfs_entry_t;

endpackage

// File: src/max_frequency_stack.sv
// Channel  | Ports                         | Carries
// ---------+-------------------------------+------------------------------------
// input    | in_valid, in_ready, in_data   | push of a value or pop request
// output   | out_valid, out_ready, out_data| popped value, status, top level
//
// One request at a time: a push runs through states P1 and P2, a pop through Q1,
// Q2 and Q3, set by dependent registered memory reads (free list and count, then
// level top; or level top, then entry, then count); all end in OUT, which loads the output register.
// Reset (rst_n, synchronous) empties the stack at once; valid bits stand in for
// the cleared count, level and free-list stores, so no clearing pass is needed.
// A stalled output holds its result and blocks the next request at its hand-off.
`include "max_frequency_stack_macros.svh"

module max_frequency_stack (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  mfs_pkg::mfs_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output mfs_pkg::mfs_out_t out_data
);

  localparam int VB  = mfs_pkg::VALUE_BITS;
  localparam int NV  = mfs_pkg::NUM_VALUES;
  localparam int CAP = mfs_pkg::CAPACITY;
  localparam int SW  = mfs_pkg::SLOT_W;
  localparam int LW  = mfs_pkg::LVL_W;

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_P1   = 3'd1;
  localparam logic [2:0] S_P2   = 3'd2;
  localparam logic [2:0] S_Q1   = 3'd3;
  localparam logic [2:0] S_Q2   = 3'd4;
  localparam logic [2:0] S_Q3   = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]    state_r, state_nxt;
  logic [LW-1:0] highest_r, highest_nxt;
  logic [LW-1:0] free_cnt_r, free_cnt_nxt;
  logic [NV-1:0] cnt_vld_r, cnt_vld_nxt;
  logic [CAP-1:0] lvl_vld_r, lvl_vld_nxt;
  logic [CAP-1:0] fr_vld_r, fr_vld_nxt;
  logic [VB-1:0] val_r, val_nxt;
  logic [SW-1:0] slot_r, slot_nxt;
  logic [LW-1:0] below_r, below_nxt;
  logic [LW-1:0] cnt_r, cnt_nxt;
  logic [7:0]    pop_val_r, pop_val_nxt;
  logic [1:0]    status_r, status_nxt;
  mfs_pkg::mfs_out_t out_r, out_nxt;
  logic          out_valid_r, out_valid_nxt;

  // Memory ports
  logic [LW-1:0] cnt_mem [NV];
  logic [VB-1:0] cnt_raddr, cnt_waddr;
  logic [LW-1:0] cnt_wdata, cnt_q;
  logic          cnt_we;

  logic [LW-1:0] lvl_mem [CAP];
  logic [SW-1:0] lvl_raddr, lvl_waddr;
  logic [LW-1:0] lvl_wdata, lvl_q;
  logic          lvl_we;

  mfs_pkg::mfs_entry_t ent_mem [CAP];
  logic [SW-1:0] ent_raddr, ent_waddr;
  mfs_pkg::mfs_entry_t ent_wdata, ent_q;
  logic          ent_we;

  logic [SW-1:0] fr_mem [CAP];
  logic [SW-1:0] fr_raddr, fr_waddr;
  logic [SW-1:0] fr_wdata, fr_q;
  logic          fr_we;

  // Helpers
  logic [LW-1:0] fc_m1, hl_m1, cnt_cur, slot_cur, cnt_inc, fr_dflt;

  assign fc_m1   = free_cnt_r - LW'(1);
  assign hl_m1   = highest_r - LW'(1);
  assign cnt_inc = cnt_r + LW'(1);
  assign fr_dflt = LW'(CAP) - free_cnt_r;

  // Count store: value -> number held
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_q <= cnt_mem[cnt_raddr];
  end

  // Level top store: level-1 -> top slot
  always_ff @(posedge clk) begin
    if (lvl_we) begin
      lvl_mem[lvl_waddr] <= lvl_wdata;
    end
    lvl_q <= lvl_mem[lvl_raddr];
  end

  // Entry store: slot -> value and link below
  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    ent_q <= ent_mem[ent_raddr];
  end

  // Free list store
  always_ff @(posedge clk) begin
    if (fr_we) begin
      fr_mem[fr_waddr] <= fr_wdata;
    end
    fr_q <= fr_mem[fr_raddr];
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    highest_nxt   = highest_r;
    free_cnt_nxt  = free_cnt_r;
    cnt_vld_nxt   = cnt_vld_r;
    lvl_vld_nxt   = lvl_vld_r;
    fr_vld_nxt    = fr_vld_r;
    val_nxt       = val_r;
    slot_nxt      = slot_r;
    below_nxt     = below_r;
    cnt_nxt       = cnt_r;
    pop_val_nxt   = pop_val_r;
    status_nxt    = status_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cnt_raddr = val_r;
    cnt_waddr = val_r;
    cnt_wdata = cnt_inc;
    cnt_we    = 1'b0;
    lvl_raddr = hl_m1[SW-1:0];
    lvl_waddr = hl_m1[SW-1:0];
    lvl_wdata = below_r;
    lvl_we    = 1'b0;
    ent_raddr = slot_r;
    ent_waddr = slot_r;
    ent_wdata = ent_q;
    ent_we    = 1'b0;
    fr_raddr  = fc_m1[SW-1:0];
    fr_waddr  = free_cnt_r[SW-1:0];
    fr_wdata  = slot_r;
    fr_we     = 1'b0;
    cnt_cur   = cnt_vld_r[val_r] ? cnt_q : '0;
    slot_cur  = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          val_nxt     = in_data.push_value[VB-1:0];
          pop_val_nxt = '0;
          if (in_data.cmd == mfs_pkg::CMD_PUSH) begin
            if (free_cnt_r == '0) begin
              status_nxt = mfs_pkg::ST_FULL;
              state_nxt  = S_OUT;
            end else begin
              cnt_raddr = in_data.push_value[VB-1:0];
              state_nxt = S_P1;
            end
          end else begin
            if (highest_r == '0) begin
              status_nxt = mfs_pkg::ST_EMPTY;
              state_nxt  = S_OUT;
            end else begin
              state_nxt = S_Q1;
            end
          end
        end
      end

      // Push: slot from free list, count of the value
      S_P1: begin
        slot_nxt = fr_vld_r[fc_m1[SW-1:0]] ? fr_q : fr_dflt[SW-1:0];
        if (cnt_cur == LW'(CAP)) begin
          status_nxt = mfs_pkg::ST_FULL;
          state_nxt  = S_OUT;
        end else begin
          cnt_nxt   = cnt_cur;
          lvl_raddr = cnt_cur[SW-1:0];
          state_nxt = S_P2;
        end
      end

      // Push: link onto level stack, bump count
      S_P2: begin
        ent_we          = 1'b1;
        ent_wdata.value = val_r;
        ent_wdata.below = lvl_vld_r[cnt_r[SW-1:0]] ? lvl_q : mfs_pkg::NONE_SLOT;
        lvl_we          = 1'b1;
        lvl_waddr       = cnt_r[SW-1:0];
        lvl_wdata       = {1'b0, slot_r};
        lvl_vld_nxt[cnt_r[SW-1:0]] = 1'b1;
        cnt_we          = 1'b1;
        cnt_vld_nxt[val_r] = 1'b1;
        free_cnt_nxt    = fc_m1;
        if (cnt_inc > highest_r) begin
          highest_nxt = cnt_inc;
        end
        status_nxt = mfs_pkg::ST_OK;
        state_nxt  = S_OUT;
      end

      // Pop: top slot of the highest level
      S_Q1: begin
        slot_cur = lvl_vld_r[hl_m1[SW-1:0]] ? lvl_q : mfs_pkg::NONE_SLOT;
        if (slot_cur >= LW'(CAP)) begin
          status_nxt = mfs_pkg::ST_EMPTY;
          state_nxt  = S_OUT;
        end else begin
          slot_nxt  = slot_cur[SW-1:0];
          ent_raddr = slot_cur[SW-1:0];
          state_nxt = S_Q2;
        end
      end

      // Pop: unlink entry, return slot to free list
      S_Q2: begin
        val_nxt   = ent_q.value;
        below_nxt = ent_q.below;
        cnt_raddr = ent_q.value;
        lvl_we    = 1'b1;
        lvl_wdata = ent_q.below;
        lvl_vld_nxt[hl_m1[SW-1:0]] = 1'b1;
        if (free_cnt_r < LW'(CAP)) begin
          fr_we        = 1'b1;
          fr_vld_nxt[free_cnt_r[SW-1:0]] = 1'b1;
          free_cnt_nxt = free_cnt_r + LW'(1);
        end
        state_nxt = S_Q3;
      end

      // Pop: lower count, drop the level if it emptied
      S_Q3: begin
        if (cnt_cur != '0) begin
          cnt_we    = 1'b1;
          cnt_wdata = cnt_cur - LW'(1);
          cnt_vld_nxt[val_r] = 1'b1;
        end
        if (below_r >= LW'(CAP)) begin
          highest_nxt = hl_m1;
        end
        pop_val_nxt = 8'(val_r);
        status_nxt  = mfs_pkg::ST_OK;
        state_nxt   = S_OUT;
      end

      // Hand the result to the output register
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.pop_value = pop_val_r;
          out_nxt.status    = status_r;
          out_nxt.top_level = 7'(highest_r);
          out_valid_nxt     = 1'b1;
          state_nxt         = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      highest_r   <= '0;
      free_cnt_r  <= LW'(CAP);
      cnt_vld_r   <= '0;
      lvl_vld_r   <= '0;
      fr_vld_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      highest_r   <= highest_nxt;
      free_cnt_r  <= free_cnt_nxt;
      cnt_vld_r   <= cnt_vld_nxt;
      lvl_vld_r   <= lvl_vld_nxt;
      fr_vld_r    <= fr_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    val_r     <= val_nxt;
    slot_r    <= slot_nxt;
    below_r   <= below_nxt;
    cnt_r     <= cnt_nxt;
    pop_val_r <= pop_val_nxt;
    status_r  <= status_nxt;
    out_r     <= out_nxt;
  end

  // Checks
  `MFS_ALWAYS(a_free_bound, clk, rst_n, free_cnt_r <= LW'(CAP), "free count above capacity")
  `MFS_IMPLIES(a_empty_all_free, clk, rst_n, highest_r == '0, free_cnt_r == LW'(CAP),
    "stack empty but entries in use")
  `MFS_IMPLIES(a_err_no_value, clk, rst_n, out_valid_r && out_r.status != mfs_pkg::ST_OK,
    out_r.pop_value == '0, "error result carries a value")
  `MFS_NEXT(a_push_alloc, clk, rst_n, state_r == S_P2, free_cnt_r == $past(free_cnt_r) - LW'(1),
    "push did not take a free entry")

endmodule
